>>> hw/rtl/bit_pkg.sv
`default_nettype none
package bit_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Request kinds.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_E = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR,
    ST_RD,
    ST_RD_CAP,
    ST_CP_START,
    ST_CP_RD,
    ST_CP_WR,
    ST_SC_START,
    ST_NB_RD,
    ST_NB_CAP,
    ST_EVAL,
    ST_PASS_END,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pix;
  } req_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  pixel;
    logic [15:0] count;
  } res_t;

  // Neighbors: bit 0 n, 1 ne, 2 e, 3 se, 4 s, 5 sw, 6 w, 7 nw.
  function automatic logic thin_clear(input logic [7:0] nb, input dir_t dir);
    logic n, ne, e, se, s, sw, w, nw, side, simple;
    logic [3:0] sum;
    n  = nb[0]; ne = nb[1]; e  = nb[2]; se = nb[3];
    s  = nb[4]; sw = nb[5]; w  = nb[6]; nw = nb[7];
    case (dir)
      DIR_N:   side = n;
      DIR_S:   side = s;
      DIR_E:   side = e;
      default: side = w;
    endcase
    simple = 1'b1;
    if (!n && !s && (nw | w | sw) && (ne | e | se)) simple = 1'b0;
    if (!e && !w && (nw | n | ne) && (se | s | sw)) simple = 1'b0;
    if (!w && !n && nw && (ne | e | se | s | sw)) simple = 1'b0;
    if (!e && !n && ne && (se | s | sw | w | nw)) simple = 1'b0;
    if (!w && !s && sw && (nw | n | ne | e | se)) simple = 1'b0;
    if (!e && !s && se && (sw | w | nw | n | ne)) simple = 1'b0;
    sum = 4'(n) + 4'(ne) + 4'(e) + 4'(se) + 4'(s) + 4'(sw) + 4'(w) + 4'(nw);
    return !side && simple && (sum >= 4'd2);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bit_engine.sv
`default_nettype none
module bit_engine
  import bit_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  parameter int RW = $clog2(MAX_ROWS + 1),
  parameter int CW = $clog2(MAX_COLS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire req_t          req,
  input  wire logic [RW-1:0] rows,
  input  wire logic [CW-1:0] cols,
  output logic               idle,
  output res_t               res
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);

  state_t state, state_next;
  req_t q;
  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [3:0] k;
  logic [8:0] nb;
  dir_t dir;
  logic chg;
  logic [15:0] rounds;
  logic [7:0] pix_q;

  logic [7:0] img_mem [DEPTH];
  logic       snap_mem [DEPTH];
  logic [7:0] img_rd;
  logic       snap_rd;
  logic          img_we, snap_we, snap_wd;
  logic [AW-1:0] img_waddr, img_raddr, snap_waddr, snap_raddr;
  logic [7:0]    img_wdata;

  logic in_bounds, last_cp, last_sc, clear_px;
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic [AW-1:0] req_addr, cur_addr, nb_addr;

  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_waddr] <= img_wdata;
    img_rd <= img_mem[img_raddr];
    if (snap_we) snap_mem[snap_waddr] <= snap_wd;
    snap_rd <= snap_mem[snap_raddr];
  end

  assign in_bounds = (32'(q.row) < 32'(rows)) && (32'(q.col) < 32'(cols));
  assign req_addr = AW'(32'(q.row) * MAX_COLS + 32'(q.col));
  assign cur_addr = AW'(32'(r) * MAX_COLS + 32'(c));
  assign nb_addr  = AW'(32'(nr) * MAX_COLS + 32'(nc));
  assign last_cp  = (r == rows - RW'(1)) && (c == cols - CW'(1));
  assign last_sc  = (r == rows - RW'(2)) && (c == cols - CW'(2));
  assign clear_px = nb[0] && thin_clear(nb[8:1], dir);

  // Neighbor offsets in the order center, n, ne, e, se, s, sw, w, nw.
  always_comb begin
    nr = r;
    nc = c;
    case (k)
      4'd1:    nr = r - RW'(1);
      4'd2:    begin nr = r - RW'(1); nc = c + CW'(1); end
      4'd3:    nc = c + CW'(1);
      4'd4:    begin nr = r + RW'(1); nc = c + CW'(1); end
      4'd5:    nr = r + RW'(1);
      4'd6:    begin nr = r + RW'(1); nc = c - CW'(1); end
      4'd7:    nc = c - CW'(1);
      4'd8:    begin nr = r - RW'(1); nc = c - CW'(1); end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req.kind)
            REQ_WRITE: state_next = ST_WR;
            REQ_READ:  state_next = ST_RD;
            REQ_RUN:   state_next = ST_CP_START;
            default:   state_next = ST_FIN;
          endcase
        end
      end
      ST_WR:       state_next = ST_FIN;
      ST_RD:       state_next = ST_RD_CAP;
      ST_RD_CAP:   state_next = ST_FIN;
      ST_CP_START: state_next = (rows == '0 || cols == '0) ? ST_SC_START : ST_CP_RD;
      ST_CP_RD:    state_next = ST_CP_WR;
      ST_CP_WR:    state_next = last_cp ? ST_SC_START : ST_CP_RD;
      ST_SC_START: state_next = (rows < RW'(3) || cols < CW'(3)) ? ST_PASS_END : ST_NB_RD;
      ST_NB_RD:    state_next = ST_NB_CAP;
      ST_NB_CAP:   state_next = ((k == 4'd0 && !snap_rd) || k == 4'd8) ? ST_EVAL : ST_NB_RD;
      ST_EVAL:     state_next = last_sc ? ST_PASS_END : ST_NB_RD;
      ST_PASS_END: state_next = (dir == DIR_W && !chg) ? ST_FIN : ST_CP_START;
      ST_FIN:      state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    img_we     = 1'b0;
    img_waddr  = cur_addr;
    img_wdata  = 8'd0;
    img_raddr  = cur_addr;
    snap_we    = 1'b0;
    snap_waddr = cur_addr;
    snap_wd    = (img_rd != 8'd0);
    snap_raddr = nb_addr;
    idle       = (state == ST_IDLE);
    res.done   = (state == ST_FIN);
    res.pixel  = pix_q;
    res.count  = (q.kind == REQ_RUN) ? rounds : 16'd0;
    case (state)
      ST_WR: begin
        img_we    = in_bounds;
        img_waddr = req_addr;
        img_wdata = q.pix;
      end
      ST_RD:    img_raddr = req_addr;
      ST_CP_WR: snap_we = 1'b1;
      ST_EVAL:  img_we = clear_px;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          q      <= req;
          dir    <= DIR_N;
          chg    <= 1'b0;
          rounds <= 16'd0;
          pix_q  <= 8'd0;
        end
      end
      ST_RD_CAP: pix_q <= in_bounds ? img_rd : 8'd0;
      ST_CP_START: begin
        r <= '0;
        c <= '0;
      end
      ST_CP_WR: begin
        if (c == cols - CW'(1)) begin
          c <= '0;
          r <= r + RW'(1);
        end else begin
          c <= c + CW'(1);
        end
      end
      ST_SC_START: begin
        r <= RW'(1);
        c <= CW'(1);
        k <= 4'd0;
      end
      ST_NB_CAP: begin
        nb[k] <= snap_rd;
        k     <= k + 4'd1;
      end
      ST_EVAL: begin
        if (clear_px) chg <= 1'b1;
        k  <= 4'd0;
        nb <= '0;
        if (c == cols - CW'(2)) begin
          c <= CW'(1);
          r <= r + RW'(1);
        end else begin
          c <= c + CW'(1);
        end
      end
      ST_PASS_END: begin
        if (dir == DIR_W) begin
          dir <= DIR_N;
          chg <= 1'b0;
          if (rounds != 16'hFFFF) rounds <= rounds + 16'd1;
        end else begin
          dir <= dir_t'(dir + 2'd1);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/binary_image_thinning.sv
// Pixel write: ST_WR then ST_FIN before the result; pixel read: ST_RD, ST_RD_CAP, then ST_FIN.
// Run: each round is four sub-passes; a sub-pass copies the image into the
// snapshot memory with a read and a write state per pixel, then visits each interior
// pixel with a read and a capture state per snapshot read (up to 9 reads) and an evaluate state.
// One request at a time; the next transfer can be taken the cycle after the result transfer.
// rst clears control state and sets both size registers to 256; the image stays undefined.
`default_nettype none
module binary_image_thinning
  import bit_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // row_index, col_index, pixel_in
  input  wire logic [1:0]  s_tuser,  // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // pixel_out, pass_count
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  logic [8:0] image_width, image_height;
  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic start, idle;
  req_t req;
  res_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_valid) begin
      if (cfg_index == REG_IMAGE_WIDTH)  image_width  <= cfg_data;
      if (cfg_index == REG_IMAGE_HEIGHT) image_height <= cfg_data;
    end
  end

  assign rows = (32'(image_height) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(image_height);
  assign cols = (32'(image_width) > MAX_COLS) ? CW'(MAX_COLS) : CW'(image_width);

  assign s_tready = idle && !m_tvalid;
  assign start    = s_tvalid && s_tready;
  assign req.kind = s_tuser;
  assign req.row  = s_tdata[7:0];
  assign req.col  = s_tdata[15:8];
  assign req.pix  = s_tdata[23:16];

  bit_engine #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .rows (rows),
    .cols (cols),
    .idle (idle),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) m_tdata <= {res.count, res.pixel};
  end

  a_no_accept_while_full: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input ready while a result waits");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !s_tready) else $error("second request taken while busy");
  a_one_field_used: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[23:8] == 16'd0))
    else $error("pixel and pass count both set");

endmodule
`default_nettype wire
